// ===== hdl/delayed_event_timer_table_unit_assert.svh =====
// Assertion macros shared by the timer table RTL.
`ifndef DELAYED_EVENT_TIMER_TABLE_UNIT_ASSERT_SVH
`define DELAYED_EVENT_TIMER_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DETT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DETT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dett_pkg.sv =====
package dett_pkg;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_W       = $clog2(SLOTS);
  localparam int unsigned FCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FIELD_W = 10;
  localparam int unsigned DELAY_W = 14;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned ENTRY_W = CNT_W + 3 * FIELD_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_ARM   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_ARMED   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  localparam logic RK_REPORT = 1'b0;
  localparam logic RK_FIRE   = 1'b1;

  typedef enum logic {
    ALU_TRIPLE,
    ALU_DEC
  } alu_op_e;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             fire;
  } alu_res_t;

endpackage

// ===== hdl/delayed_event_timer_table_unit.sv =====
// An ignored arm goes straight to its report; any other arm scans the slots for the lowest free
// slot and reports it, or reports a full status when the table is full.
// Tick walks all slots with one shared adder, skipping idle slots, reading and then evaluating
// each armed slot, and ending with a flush; output stalls hold the walk. Clear disarms all slots.
// One item at a time; the next is taken once the walk ends, while a result may wait.
// Reset: all slots disarmed, no result pending; slot contents stay undefined.
module delayed_event_timer_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dett_pkg::KIND_W-1:0]   kind_i,
  input  logic                          still_over_i,
  input  logic [dett_pkg::FIELD_W-1:0]  source_index_i,
  input  logic [dett_pkg::FIELD_W-1:0]  target_room_i,
  input  logic [dett_pkg::FIELD_W-1:0]  target_object_i,
  input  logic [dett_pkg::DELAY_W-1:0]  delay_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          result_kind_o,
  output logic [dett_pkg::STAT_W-1:0]   arm_status_o,
  output logic [dett_pkg::SLOT_W-1:0]   slot_o,
  output logic [dett_pkg::FIELD_W-1:0]  fired_source_o,
  output logic [dett_pkg::FIELD_W-1:0]  fired_room_o,
  output logic [dett_pkg::FIELD_W-1:0]  fired_object_o,
  output logic                          last_o
);

  import dett_pkg::*;

  `include "delayed_event_timer_table_unit_assert.svh"

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_ARM_SCAN   = 3'd1;
  localparam logic [2:0] ST_ARM_EMIT   = 3'd2;
  localparam logic [2:0] ST_TICK_RD    = 3'd3;
  localparam logic [2:0] ST_TICK_EVAL  = 3'd4;
  localparam logic [2:0] ST_TICK_FLUSH = 3'd5;

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SLOTS - 1);
  localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_RESULTS);

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;
  logic [SLOTS-1:0]  armed_q, armed_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic              pend_vld_q, pend_vld_d;
  logic              out_vld_q, out_vld_d;

  logic [KIND_W-1:0]  kind_q;
  logic               still_q;
  logic [FIELD_W-1:0] src_q, room_q, obj_q;
  logic [DELAY_W-1:0] delay_q;

  logic [IDX_W-1:0]   pend_slot_q;
  logic [FIELD_W-1:0] pend_src_q, pend_room_q, pend_obj_q;

  logic               out_rk_q;
  logic [STAT_W-1:0]  out_stat_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [FIELD_W-1:0] out_src_q, out_room_q, out_obj_q;
  logic               out_last_q;

  logic               item_xfer, out_free;
  logic               arm_load, fire_load, pend_load, pend_last;
  logic               ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  alu_op_e            alu_op;
  logic [CNT_W-1:0]   alu_opd;
  alu_res_t           alu_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign item_xfer  = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;

  assign alu_op  = (state_q == ST_ARM_SCAN) ? ALU_TRIPLE : ALU_DEC;
  assign alu_opd = (state_q == ST_ARM_SCAN) ? CNT_W'(delay_q)
                                            : ram_rdata[ENTRY_W-1 -: CNT_W];

  dett_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  dett_alu u_alu (
    .op_i  (alu_op),
    .opd_i (alu_opd),
    .res_o (alu_res)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    fcnt_d     = fcnt_q;
    armed_d    = armed_q;
    stat_d     = stat_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    arm_load   = 1'b0;
    fire_load  = 1'b0;
    pend_load  = 1'b0;
    pend_last  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = {alu_res.cnt, ram_rdata[3*FIELD_W-1:0]};

    unique case (state_q)
      ST_IDLE: begin
        if (item_xfer) begin
          idx_d  = '0;
          fcnt_d = '0;
          unique case (kind_i)
            KIND_ARM: begin
              if (still_over_i) begin
                stat_d  = STAT_IGNORED;
                state_d = ST_ARM_EMIT;
              end else begin
                state_d = ST_ARM_SCAN;
              end
            end
            KIND_TICK:  state_d = ST_TICK_RD;
            KIND_CLEAR: armed_d = '0;
            default: ;
          endcase
        end
      end
      ST_ARM_SCAN: begin
        ram_wdata = {alu_res.cnt, src_q, room_q, obj_q};
        if (!armed_q[idx_q]) begin
          ram_we          = 1'b1;
          armed_d[idx_q]  = 1'b1;
          stat_d          = STAT_ARMED;
          state_d         = ST_ARM_EMIT;
        end else if (idx_q == IDX_LAST) begin
          stat_d  = STAT_FULL;
          state_d = ST_ARM_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_ARM_EMIT: begin
        if (out_free) begin
          arm_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_TICK_RD: begin
        if (armed_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = ST_TICK_EVAL;
        end else if (idx_q == IDX_LAST) begin
          state_d = ST_TICK_FLUSH;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_TICK_EVAL: begin
        if (!alu_res.fire || fcnt_q == FCNT_MAX || !pend_vld_q || out_free) begin
          ram_we = 1'b1;
          if (alu_res.fire && fcnt_q != FCNT_MAX) begin
            armed_d[idx_q] = 1'b0;
            fcnt_d         = fcnt_q + FCNT_W'(1);
            pend_load      = 1'b1;
            pend_vld_d     = 1'b1;
            if (pend_vld_q) begin
              fire_load = 1'b1;
              out_vld_d = 1'b1;
            end
          end
          if (idx_q == IDX_LAST) begin
            state_d = ST_TICK_FLUSH;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_TICK_RD;
          end
        end
      end
      ST_TICK_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          fire_load  = 1'b1;
          pend_last  = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      fcnt_q     <= '0;
      armed_q    <= '0;
      stat_q     <= STAT_ARMED;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      fcnt_q     <= fcnt_d;
      armed_q    <= armed_d;
      stat_q     <= stat_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_xfer) begin
      kind_q  <= kind_i;
      still_q <= still_over_i;
      src_q   <= source_index_i;
      room_q  <= target_room_i;
      obj_q   <= target_object_i;
      delay_q <= delay_i;
    end
    if (pend_load) begin
      pend_slot_q <= idx_q;
      pend_src_q  <= ram_rdata[3*FIELD_W-1 -: FIELD_W];
      pend_room_q <= ram_rdata[2*FIELD_W-1 -: FIELD_W];
      pend_obj_q  <= ram_rdata[FIELD_W-1:0];
    end
    if (arm_load) begin
      out_rk_q   <= RK_REPORT;
      out_stat_q <= stat_q;
      out_slot_q <= (stat_q == STAT_ARMED) ? SLOT_W'(idx_q) : '0;
      out_src_q  <= '0;
      out_room_q <= '0;
      out_obj_q  <= '0;
      out_last_q <= 1'b1;
    end else if (fire_load) begin
      out_rk_q   <= RK_FIRE;
      out_stat_q <= STAT_ARMED;
      out_slot_q <= SLOT_W'(pend_slot_q);
      out_src_q  <= pend_src_q;
      out_room_q <= pend_room_q;
      out_obj_q  <= pend_obj_q;
      out_last_q <= pend_last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_kind_o  = out_rk_q;
  assign arm_status_o   = out_stat_q;
  assign slot_o         = out_slot_q;
  assign fired_source_o = out_src_q;
  assign fired_room_o   = out_room_q;
  assign fired_object_o = out_obj_q;
  assign last_o         = out_last_q;

  `DETT_ASSERT_NOW(a_pend_in_tick, clk_i, rst_ni,
    pend_vld_q,
    state_q == ST_TICK_RD || state_q == ST_TICK_EVAL || state_q == ST_TICK_FLUSH,
    "pending fire outside a tick walk")
  `DETT_ASSERT_NOW(a_fire_bound, clk_i, rst_ni,
    1'b1, fcnt_q <= FCNT_MAX, "fire count beyond limit")
  `DETT_ASSERT_NOW(a_armed_slot_set, clk_i, rst_ni,
    state_q == ST_ARM_EMIT && stat_q == STAT_ARMED && kind_q == KIND_ARM && !still_q,
    armed_q[idx_q], "armed report for a free slot")
  `DETT_ASSERT_NEXT(a_fire_disarms, clk_i, rst_ni,
    state_q == ST_TICK_EVAL && ram_we && alu_res.fire && fcnt_q != FCNT_MAX,
    pend_vld_q, "fired slot not held for output")

endmodule

// ===== hdl/dett_ram.sv =====
module dett_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dett_alu.sv =====
module dett_alu (
  input  dett_pkg::alu_op_e               op_i,
  input  logic [dett_pkg::CNT_W-1:0]      opd_i,
  output dett_pkg::alu_res_t              res_o
);

  import dett_pkg::*;

  logic [CNT_W+1:0] sum;

  // one adder: 2x+x for arming, x-1 for the countdown
  always_comb begin
    if (op_i == ALU_TRIPLE) begin
      sum = {1'b0, opd_i, 1'b0} + {2'b00, opd_i};
    end else begin
      sum = {2'b00, opd_i} + {(CNT_W+2){1'b1}};
    end
  end

  always_comb begin
    res_o.fire = 1'b0;
    unique case (op_i)
      ALU_TRIPLE: begin
        res_o.cnt = (sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : sum[CNT_W-1:0];
      end
      ALU_DEC: begin
        res_o.fire = (opd_i <= CNT_W'(1));
        res_o.cnt  = res_o.fire ? '0 : sum[CNT_W-1:0];
      end
      default: begin
        res_o.cnt = '0;
      end
    endcase
  end

endmodule
